[hdl/epr_pkg.sv]
// Shared types, widths and constants of the ellipse phantom rasterizer.
package epr_pkg;

    // Number of shape slots held in the shape memory
    localparam int MAX_SHAPES = 32;

    // Field widths
    localparam int OP_W       = 1;
    localparam int SLOT_W     = 5;
    localparam int INT_W      = 16;
    localparam int POS_W      = 18;
    localparam int AXIS_W     = 24;
    localparam int ROT_W      = 18;
    localparam int OUT_W      = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam int COUNT_W    = 6;

    // Slot addressing and shape counting
    localparam int ADDR_W = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
    localparam int CNT_W  = $clog2(MAX_SHAPES + 1);
    localparam int CMP_W  = 8;

    // Datapath widths
    localparam int Q_W   = POS_W + 1;          // q0, q1
    localparam int M_W   = ROT_W + 1;          // c, s or c-s, c+s
    localparam int P_W   = Q_W + M_W;          // first products
    localparam int UV_W  = P_W + 1;            // rotated coordinates
    localparam int XY_W  = UV_W + AXIS_W;      // scaled coordinates, Q.48
    localparam int MAG_W = XY_W;               // magnitudes
    localparam int SUM_W = MAG_W + 1;          // diamond sum
    localparam int TR_W  = 25;                 // truncated magnitude, Q.24
    localparam int SQ_W  = 2 * TR_W;           // squares, Q.48
    localparam int SQS_W = SQ_W + 1;           // sum of squares

    // Fixed point positions of the coverage tests
    localparam int FRAC_CUT = 24;              // bits dropped before squaring
    localparam int TWO_POS  = 49;              // 2.0 at Q.48
    localparam int ONE_POS  = 48;              // 1.0 at Q.48

    // Accumulator and saturation
    localparam int ACC_W = INT_W + CNT_W + 1;
    localparam int EXT_W = ACC_W + OUT_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_EVAL = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_KIND  = 1'b1;

    // Shape kinds
    localparam logic KIND_ELLIPSE = 1'b0;
    localparam logic KIND_DIAMOND = 1'b1;

    // One stored shape slot
    typedef struct packed {
        logic [INT_W-1:0]  int_re;
        logic [INT_W-1:0]  int_im;
        logic [POS_W-1:0]  cen_x;
        logic [POS_W-1:0]  cen_y;
        logic [AXIS_W-1:0] iax;
        logic [AXIS_W-1:0] iay;
        logic [ROT_W-1:0]  cos_a;
        logic [ROT_W-1:0]  sin_a;
    } shape_t;

    localparam int SHAPE_W = $bits(shape_t);

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic              start;     // latch point, clear sums
        logic              wr_en;     // store shape slot
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;     // fetch shape slot into the pipe
        logic [ADDR_W-1:0] rd_addr;
        logic              kind;      // coverage test select
        logic              out_load;  // move sums into the output register
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic busy;      // shapes still in flight
        logic out_free;  // output register can take a result this cycle
    } dp_stat_t;

endpackage

[hdl/epr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module epr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/epr_ctrl.sv]
// Controller: configuration registers, transaction acceptance and slot sequencing.
module epr_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [epr_pkg::OP_W-1:0]         op,
    input  logic [epr_pkg::SLOT_W-1:0]       slot,
    input  logic                             cfg_we,
    input  logic [epr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [epr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  epr_pkg::dp_stat_t                stat,
    output epr_pkg::ctl_cmd_t                cmd
);

    import epr_pkg::*;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     cnt_inc;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 kind_reg, kind_next;
    logic [CMP_W-1:0]     count_ext;
    logic [CMP_W-1:0]     lim_ext;
    logic [CMP_W-1:0]     slot_ext;
    logic [CNT_W-1:0]     n_lim;
    logic                 slot_ok;
    logic                 in_acc;

    // Transaction acceptance
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;

    // Visited slot count, clipped to capacity
    assign count_ext = CMP_W'(count_reg);
    assign lim_ext   = (count_ext > CMP_W'(MAX_SHAPES)) ? CMP_W'(MAX_SHAPES) : count_ext;
    assign n_lim     = lim_ext[CNT_W-1:0];
    assign cnt_inc   = cnt_reg + CNT_W'(1);

    // Loads to slots beyond capacity are dropped
    assign slot_ext = CMP_W'(slot);
    assign slot_ok  = (slot_ext < CMP_W'(MAX_SHAPES));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (op == OP_EVAL))
                begin
                    state_next = (n_lim == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cnt_inc == n_lim)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.busy && stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd          = '0;
        cmd.kind     = kind_reg;
        cmd.wr_addr  = slot_ext[ADDR_W-1:0];
        cmd.rd_addr  = cnt_reg[ADDR_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.wr_en = in_acc && (op == OP_LOAD) && slot_ok;
                cmd.start = in_acc && (op == OP_EVAL);
            end
            ST_RUN:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd.out_load = !stat.busy && stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Slot issue counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.start)
        begin
            cnt_next = '0;
        end
        else if (cmd.rd_en)
        begin
            cnt_next = cnt_inc;
        end
    end

    // Configuration writes
    always_comb
    begin
        count_next = count_reg;
        kind_next  = kind_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SHAPE_COUNT: count_next = cfg_data[COUNT_W-1:0];
                CFG_SHAPE_KIND:  kind_next  = cfg_data[0];
                default:         count_next = count_reg;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            count_reg <= '0;
            kind_reg  <= KIND_ELLIPSE;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            count_reg <= count_next;
            kind_reg  <= kind_next;
        end
    end

    // Result is only released once the pipe is empty
    a_out_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !stat.busy)
        else $error("result released while shapes still in flight");

    // Never fetch a slot past the visited count
    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (cnt_reg < n_lim))
        else $error("slot fetch beyond shape count");

    // An evaluate transaction always leaves the idle state
    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg != ST_IDLE))
        else $error("evaluate accepted but controller stayed idle");

endmodule

[hdl/epr_datapath.sv]
// Datapath: shape memory, coverage pipeline, intensity sums and output register.
module epr_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  epr_pkg::ctl_cmd_t                   cmd,
    output epr_pkg::dp_stat_t                   stat,
    input  logic signed [epr_pkg::INT_W-1:0]    intensity_re,
    input  logic signed [epr_pkg::INT_W-1:0]    intensity_im,
    input  logic signed [epr_pkg::POS_W-1:0]    center_x,
    input  logic signed [epr_pkg::POS_W-1:0]    center_y,
    input  logic signed [epr_pkg::AXIS_W-1:0]   inv_axis_x,
    input  logic signed [epr_pkg::AXIS_W-1:0]   inv_axis_y,
    input  logic signed [epr_pkg::ROT_W-1:0]    cos_angle,
    input  logic signed [epr_pkg::ROT_W-1:0]    sin_angle,
    input  logic signed [epr_pkg::POS_W-1:0]    pos_x,
    input  logic signed [epr_pkg::POS_W-1:0]    pos_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [epr_pkg::OUT_W-1:0]    value_re,
    output logic signed [epr_pkg::OUT_W-1:0]    value_im
);

    import epr_pkg::*;

    localparam logic signed [EXT_W-1:0] OUT_MAX_E = EXT_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [EXT_W-1:0] OUT_MIN_E = -OUT_MAX_E - EXT_W'(1);
    localparam logic [SUM_W-1:0]        DIAMOND_LIM = SUM_W'(1) << TWO_POS;
    localparam logic [SQS_W-1:0]        ELLIPSE_LIM = SQS_W'(1) << ONE_POS;

    // Clamp a sum to the output range
    function automatic logic [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [EXT_W-1:0] ve;
        ve = EXT_W'(v);
        if (ve > OUT_MAX_E)
        begin
            ve = OUT_MAX_E;
        end
        else if (ve < OUT_MIN_E)
        begin
            ve = OUT_MIN_E;
        end
        return ve[OUT_W-1:0];
    endfunction

    shape_t wr_shape;
    shape_t rd_shape;

    // Point of the current evaluate
    logic signed [POS_W-1:0]  px_reg, py_reg;

    // Pipeline valid bits
    logic rd_vld_reg, va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg, vg_reg;

    // Stage A: offsets and rotation coefficients
    logic signed [Q_W-1:0]    q0_next, q1_next, q0_reg, q1_reg;
    logic signed [M_W-1:0]    m0_next, m1_next, m0_reg, m1_reg;
    logic signed [AXIS_W-1:0] a_iax_reg, a_iay_reg;

    // Stage B: first products
    logic signed [P_W-1:0]    p00_reg, p11_reg, p10_reg, p01_reg;
    logic signed [AXIS_W-1:0] b_iax_reg, b_iay_reg;

    // Stage C: rotated coordinates
    logic signed [UV_W-1:0]   u_reg, v_reg;
    logic signed [AXIS_W-1:0] c_iax_reg, c_iay_reg;

    // Stage D: scaled coordinates
    logic signed [XY_W-1:0]   x_reg, y_reg;

    // Stage E: magnitudes
    logic [MAG_W-1:0]         ax_next, ay_next, ax_reg, ay_reg;

    // Stage F: test terms
    logic [SUM_W-1:0]         dsum;
    logic [TR_W-1:0]          tx, ty;
    logic                     dia_hit_reg, over_reg;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;

    // Stage G: coverage
    logic [SQS_W-1:0]         sqsum;
    logic                     hit_next, hit_reg;

    // Intensities ride along with each slot
    logic signed [INT_W-1:0]  ire_reg [7];
    logic signed [INT_W-1:0]  iim_reg [7];

    // Sums and output register
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;
    logic signed [ACC_W-1:0]  acc_re_next, acc_im_next;
    logic                     out_full_reg;
    logic signed [OUT_W-1:0]  out_re_reg, out_im_reg;

    // Shape memory
    always_comb
    begin
        wr_shape.int_re = intensity_re;
        wr_shape.int_im = intensity_im;
        wr_shape.cen_x  = center_x;
        wr_shape.cen_y  = center_y;
        wr_shape.iax    = inv_axis_x;
        wr_shape.iay    = inv_axis_y;
        wr_shape.cos_a  = cos_angle;
        wr_shape.sin_a  = sin_angle;
    end

    epr_ram #(
        .WIDTH (SHAPE_W),
        .DEPTH (MAX_SHAPES)
    ) u_shape_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (cmd.wr_addr),
        .wdata (wr_shape),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (rd_shape)
    );

    // Stage A logic: q = (c_x - p_y, p_x + c_y), coefficients per kind
    always_comb
    begin
        q0_next = Q_W'($signed(rd_shape.cen_x)) - Q_W'(py_reg);
        q1_next = Q_W'(px_reg) + Q_W'($signed(rd_shape.cen_y));
        if (cmd.kind == KIND_DIAMOND)
        begin
            m0_next = M_W'($signed(rd_shape.cos_a)) - M_W'($signed(rd_shape.sin_a));
            m1_next = M_W'($signed(rd_shape.cos_a)) + M_W'($signed(rd_shape.sin_a));
        end
        else
        begin
            m0_next = M_W'($signed(rd_shape.cos_a));
            m1_next = M_W'($signed(rd_shape.sin_a));
        end
    end

    // Stage E logic: magnitudes of the scaled coordinates
    always_comb
    begin
        ax_next = x_reg[XY_W-1] ? (~MAG_W'(x_reg) + MAG_W'(1)) : MAG_W'(x_reg);
        ay_next = y_reg[XY_W-1] ? (~MAG_W'(y_reg) + MAG_W'(1)) : MAG_W'(y_reg);
    end

    // Stage F logic: diamond sum and truncated ellipse terms
    assign dsum = SUM_W'(ax_reg) + SUM_W'(ay_reg);
    assign tx   = ax_reg[FRAC_CUT+TR_W-1:FRAC_CUT];
    assign ty   = ay_reg[FRAC_CUT+TR_W-1:FRAC_CUT];

    // Stage G logic: final coverage decision
    always_comb
    begin
        sqsum = SQS_W'(sqx_reg) + SQS_W'(sqy_reg);
        if (cmd.kind == KIND_DIAMOND)
        begin
            hit_next = dia_hit_reg;
        end
        else
        begin
            hit_next = !over_reg && (sqsum <= ELLIPSE_LIM);
        end
    end

    // Intensity sums
    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (cmd.start)
        begin
            acc_re_next = '0;
            acc_im_next = '0;
        end
        else if (vg_reg && hit_reg)
        begin
            acc_re_next = acc_re_reg + ACC_W'(ire_reg[6]);
            acc_im_next = acc_im_reg + ACC_W'(iim_reg[6]);
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
        end

        q0_reg    <= q0_next;
        q1_reg    <= q1_next;
        m0_reg    <= m0_next;
        m1_reg    <= m1_next;
        a_iax_reg <= $signed(rd_shape.iax);
        a_iay_reg <= $signed(rd_shape.iay);

        p00_reg   <= P_W'(m0_reg) * P_W'(q0_reg);
        p11_reg   <= P_W'(m1_reg) * P_W'(q1_reg);
        p10_reg   <= P_W'(m1_reg) * P_W'(q0_reg);
        p01_reg   <= P_W'(m0_reg) * P_W'(q1_reg);
        b_iax_reg <= a_iax_reg;
        b_iay_reg <= a_iay_reg;

        u_reg     <= UV_W'(p00_reg) + UV_W'(p11_reg);
        v_reg     <= UV_W'(p10_reg) - UV_W'(p01_reg);
        c_iax_reg <= b_iax_reg;
        c_iay_reg <= b_iay_reg;

        x_reg     <= XY_W'(u_reg) * XY_W'(c_iax_reg);
        y_reg     <= XY_W'(v_reg) * XY_W'(c_iay_reg);

        ax_reg    <= ax_next;
        ay_reg    <= ay_next;

        dia_hit_reg <= (dsum <= DIAMOND_LIM);
        over_reg    <= (|ax_reg[MAG_W-1:TWO_POS]) || (|ay_reg[MAG_W-1:TWO_POS]);
        sqx_reg     <= SQ_W'(tx) * SQ_W'(tx);
        sqy_reg     <= SQ_W'(ty) * SQ_W'(ty);

        hit_reg   <= hit_next;

        ire_reg[0] <= $signed(rd_shape.int_re);
        iim_reg[0] <= $signed(rd_shape.int_im);
        for (int i = 1; i < 7; i++)
        begin
            ire_reg[i] <= ire_reg[i-1];
            iim_reg[i] <= iim_reg[i-1];
        end

        if (cmd.out_load)
        begin
            out_re_reg <= sat_out(acc_re_reg);
            out_im_reg <= sat_out(acc_im_reg);
        end
    end

    // Pipeline valid bits, sums and output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
            vc_reg       <= 1'b0;
            vd_reg       <= 1'b0;
            ve_reg       <= 1'b0;
            vf_reg       <= 1'b0;
            vg_reg       <= 1'b0;
            acc_re_reg   <= '0;
            acc_im_reg   <= '0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
            va_reg     <= rd_vld_reg;
            vb_reg     <= va_reg;
            vc_reg     <= vb_reg;
            vd_reg     <= vc_reg;
            ve_reg     <= vd_reg;
            vf_reg     <= ve_reg;
            vg_reg     <= vf_reg;
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
            if (cmd.out_load)
            begin
                out_full_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    // Status and result ports
    assign stat.busy     = rd_vld_reg || va_reg || vb_reg || vc_reg
                        || vd_reg || ve_reg || vf_reg || vg_reg;
    assign stat.out_free = !out_full_reg || !out_stall;
    assign out_valid     = out_full_reg;
    assign value_re      = out_re_reg;
    assign value_im      = out_im_reg;

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_full_reg && out_stall) |-> !cmd.out_load)
        else $error("output register overwritten while stalled");

    // A new evaluate starts only on an empty pipe
    a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !stat.busy)
        else $error("evaluate started with shapes in flight");

    // Every fetched slot reaches the coverage stage
    a_fetch_reaches_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> ##8 vg_reg)
        else $error("fetched slot lost in the pipeline");

endmodule

[hdl/ellipse_phantom_rasterizer_unit.sv]
// Top level of the ellipse phantom rasterizer: controller plus datapath.
//
//  port group   dir   handshake                  payload
//  in           in    in_valid / in_stall        op, slot, intensity, center, axes, angle, pos
//  out          out   out_valid / out_stall      value_re, value_im
//  cfg          in    cfg_we                     cfg_index, cfg_data
//
// A load transaction writes the shape memory directly.
// An evaluate transaction visits n = min(shape_count, MAX_SHAPES) slots, none
// when n is zero: one shape slot per cycle is fetched from the single
// read port of the shape memory into an eight-deep multiply/compare pipeline,
// then the pipe drains.
// Reset clears shape_count and shape_kind to zero; shape slots hold no reset.
// One result waits in the output register while the next evaluate runs; a
// stalled output only holds the controller at the end of the following one.
module ellipse_phantom_rasterizer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [epr_pkg::OP_W-1:0]            op,
    input  logic [epr_pkg::SLOT_W-1:0]          slot,
    input  logic signed [epr_pkg::INT_W-1:0]    intensity_re,
    input  logic signed [epr_pkg::INT_W-1:0]    intensity_im,
    input  logic signed [epr_pkg::POS_W-1:0]    center_x,
    input  logic signed [epr_pkg::POS_W-1:0]    center_y,
    input  logic signed [epr_pkg::AXIS_W-1:0]   inv_axis_x,
    input  logic signed [epr_pkg::AXIS_W-1:0]   inv_axis_y,
    input  logic signed [epr_pkg::ROT_W-1:0]    cos_angle,
    input  logic signed [epr_pkg::ROT_W-1:0]    sin_angle,
    input  logic signed [epr_pkg::POS_W-1:0]    pos_x,
    input  logic signed [epr_pkg::POS_W-1:0]    pos_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [epr_pkg::OUT_W-1:0]    value_re,
    output logic signed [epr_pkg::OUT_W-1:0]    value_im,
    input  logic                                cfg_we,
    input  logic [epr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [epr_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import epr_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // Sequencer
    epr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .slot      (slot),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Shape memory and coverage pipeline
    epr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .intensity_re (intensity_re),
        .intensity_im (intensity_im),
        .center_x     (center_x),
        .center_y     (center_y),
        .inv_axis_x   (inv_axis_x),
        .inv_axis_y   (inv_axis_y),
        .cos_angle    (cos_angle),
        .sin_angle    (sin_angle),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value_re     (value_re),
        .value_im     (value_im)
    );

endmodule

[sim/ellipse_phantom_rasterizer_unit_test.sv]
// Self-checking testbench for the ellipse phantom rasterizer unit.
module ellipse_phantom_rasterizer_unit_test;
    import epr_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    // One input transaction, fields as the block sees them
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [SLOT_W-1:0]        slot;
        logic signed [INT_W-1:0]  int_re;
        logic signed [INT_W-1:0]  int_im;
        logic signed [POS_W-1:0]  cen_x;
        logic signed [POS_W-1:0]  cen_y;
        logic signed [AXIS_W-1:0] iax;
        logic signed [AXIS_W-1:0] iay;
        logic signed [ROT_W-1:0]  cos_a;
        logic signed [ROT_W-1:0]  sin_a;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
    } item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
    } sum_t;

    // Directed table row: a register write or a transaction
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        item_t                 it;
        bit                    known;
        sum_t                  typed;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [OP_W-1:0] op = '0;
    logic [SLOT_W-1:0] slot = '0;
    logic signed [INT_W-1:0] intensity_re = '0;
    logic signed [INT_W-1:0] intensity_im = '0;
    logic signed [POS_W-1:0] center_x = '0;
    logic signed [POS_W-1:0] center_y = '0;
    logic signed [AXIS_W-1:0] inv_axis_x = '0;
    logic signed [AXIS_W-1:0] inv_axis_y = '0;
    logic signed [ROT_W-1:0] cos_angle = '0;
    logic signed [ROT_W-1:0] sin_angle = '0;
    logic signed [POS_W-1:0] pos_x = '0;
    logic signed [POS_W-1:0] pos_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [OUT_W-1:0] value_re;
    logic signed [OUT_W-1:0] value_im;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Mirror of the block state
    item_t shape_mem [MAX_SHAPES];
    logic [COUNT_W-1:0] shape_total = '0;
    logic shape_style = KIND_ELLIPSE;

    sum_t pending_sums[$];
    row_t plan[$];
    sum_t want;
    int error_count = 0;
    int cycle_count = 0;
    int stall_left = 0;
    bit quiet_tail = 1'b0;

    ellipse_phantom_rasterizer_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .slot(slot),
        .intensity_re(intensity_re), .intensity_im(intensity_im),
        .center_x(center_x), .center_y(center_y),
        .inv_axis_x(inv_axis_x), .inv_axis_y(inv_axis_y),
        .cos_angle(cos_angle), .sin_angle(sin_angle),
        .pos_x(pos_x), .pos_y(pos_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .value_re(value_re), .value_im(value_im),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] magnitude(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp24(longint x);
        if (x > 8388607)
            return 24'sh7FFFFF;
        if (x < -8388608)
            return 24'sh800000;
        return x[OUT_W-1:0];
    endfunction

    // Coverage test of one shape, exact in 64-bit arithmetic
    function automatic bit shape_covers(item_t sh, logic signed [POS_W-1:0] px,
                                        logic signed [POS_W-1:0] py);
        longint q0, q1, c, s, ia, ib, u, v, a, b, t;
        logic [63:0] ax, ay, tx, ty;
        logic [64:0] l1;
        q0 = longint'($signed(sh.cen_x));
        t = longint'($signed(py));
        q0 = q0 - t;
        q1 = longint'($signed(sh.cen_y));
        t = longint'($signed(px));
        q1 = q1 + t;
        c = longint'($signed(sh.cos_a));
        s = longint'($signed(sh.sin_a));
        ia = longint'($signed(sh.iax));
        ib = longint'($signed(sh.iay));
        if (shape_style == KIND_ELLIPSE)
        begin
            u = c * q0 + s * q1;
            v = s * q0 - c * q1;
            ax = magnitude(u * ia);
            ay = magnitude(v * ib);
            // at or beyond 2.0 on either axis the point is out
            if (ax >= (64'd1 << 49) || ay >= (64'd1 << 49))
                return 1'b0;
            tx = ax >> 24;
            ty = ay >> 24;
            return (tx * tx + ty * ty) <= (64'd1 << 48);
        end
        else
        begin
            // 45 degree turn folded into d = c - s, e = c + s
            a = ((c - s) * q0 + (c + s) * q1) * ia;
            b = ((c + s) * q0 - (c - s) * q1) * ib;
            l1 = {1'b0, magnitude(a)} + {1'b0, magnitude(b)};
            return l1 <= (65'd1 << 49);
        end
    endfunction

    // Sum of intensities of every visited shape that covers the point
    function automatic sum_t rasterize_point(logic signed [POS_W-1:0] px,
                                             logic signed [POS_W-1:0] py);
        sum_t r;
        longint acc_re, acc_im;
        int visits;
        acc_re = 0;
        acc_im = 0;
        visits = (shape_total > MAX_SHAPES) ? MAX_SHAPES : shape_total;
        for (int k = 0; k < visits; k++)
        begin
            if (shape_covers(shape_mem[k], px, py))
            begin
                acc_re += longint'($signed(shape_mem[k].int_re));
                acc_im += longint'($signed(shape_mem[k].int_im));
            end
        end
        r.re = clamp24(acc_re);
        r.im = clamp24(acc_im);
        return r;
    endfunction

    // Update the mirror for one accepted transaction
    task automatic track_item(input item_t it);
        if (it.op == OP_LOAD)
            shape_mem[it.slot] = it;
        else
            pending_sums.push_back(rasterize_point(it.pos_x, it.pos_y));
    endtask

    function automatic item_t noise_item();
        item_t it;
        it.op = OP_W'($urandom);
        it.slot = SLOT_W'($urandom);
        it.int_re = INT_W'($urandom);
        it.int_im = INT_W'($urandom);
        it.cen_x = POS_W'($urandom);
        it.cen_y = POS_W'($urandom);
        it.iax = AXIS_W'($urandom);
        it.iay = AXIS_W'($urandom);
        it.cos_a = ROT_W'($urandom);
        it.sin_a = ROT_W'($urandom);
        it.pos_x = POS_W'($urandom);
        it.pos_y = POS_W'($urandom);
        return it;
    endfunction

    // Plausible phantom shape: center inside the unit square, real angle
    function automatic item_t random_shape(logic [SLOT_W-1:0] where);
        item_t it;
        real theta;
        it = noise_item();
        it.op = OP_LOAD;
        it.slot = where;
        it.cen_x = POS_W'($urandom_range(0, 104000) - 52000);
        it.cen_y = POS_W'($urandom_range(0, 104000) - 52000);
        it.iax = AXIS_W'(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(65536, 1310720));
        it.iay = AXIS_W'(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(65536, 1310720));
        if ($urandom_range(0, 3) == 0)
            it.iax = -it.iax;
        if ($urandom_range(0, 3) == 0)
            it.iay = -it.iay;
        theta = $urandom_range(0, 62831) / 10000.0;
        it.cos_a = ROT_W'($rtoi($cos(theta) * 65536.0));
        it.sin_a = ROT_W'($rtoi($sin(theta) * 65536.0));
        return it;
    endfunction

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        row_t r;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        r.it = noise_item();
        r.known = 1'b0;
        r.typed = '0;
        plan.push_back(r);
    endtask

    task automatic add_load(input int where, input int ire, input int iim, input int cx,
                            input int cy, input int ia, input int ib, input int c, input int s);
        row_t r;
        r.is_cfg = 1'b0;
        r.idx = '0;
        r.data = '0;
        r.it = noise_item();
        r.it.op = OP_LOAD;
        r.it.slot = SLOT_W'(where);
        r.it.int_re = INT_W'(ire);
        r.it.int_im = INT_W'(iim);
        r.it.cen_x = POS_W'(cx);
        r.it.cen_y = POS_W'(cy);
        r.it.iax = AXIS_W'(ia);
        r.it.iay = AXIS_W'(ib);
        r.it.cos_a = ROT_W'(c);
        r.it.sin_a = ROT_W'(s);
        r.known = 1'b0;
        r.typed = '0;
        plan.push_back(r);
    endtask

    task automatic add_eval(input int px, input int py, input bit known, input int ere,
                            input int eim);
        row_t r;
        r.is_cfg = 1'b0;
        r.idx = '0;
        r.data = '0;
        r.it = noise_item();
        r.it.op = OP_EVAL;
        r.it.pos_x = POS_W'(px);
        r.it.pos_y = POS_W'(py);
        r.known = known;
        r.typed.re = OUT_W'(ere);
        r.typed.im = OUT_W'(eim);
        plan.push_back(r);
    endtask

    // Drive one transaction and hold it until the block takes it
    task automatic send_item(input item_t it);
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= it.op;
        slot <= it.slot;
        intensity_re <= it.int_re;
        intensity_im <= it.int_im;
        center_x <= it.cen_x;
        center_y <= it.cen_y;
        inv_axis_x <= it.iax;
        inv_axis_y <= it.iay;
        cos_angle <= it.cos_a;
        sin_angle <= it.sin_a;
        pos_x <= it.pos_x;
        pos_y <= it.pos_y;
        do @(posedge clk); while (in_stall);
    endtask

    // Register write once every pending result is out and the block is quiet
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SHAPE_COUNT)
            shape_total = data;
        else
            shape_style = data[0];
    endtask

    task automatic compare_field(input string name, input logic signed [OUT_W-1:0] exp_v,
                                 input logic signed [OUT_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            error_count++;
            $error("%s expected %0d got %0d", name, exp_v, act_v);
        end
    endtask

    // Result side: check, random stall bursts, run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_sums.size() == 0)
                begin
                    error_count++;
                    $error("value_re %0d value_im %0d with no evaluate pending",
                           value_re, value_im);
                end
                else
                begin
                    want = pending_sums.pop_front();
                    compare_field("value_re", want.re, value_re);
                    compare_field("value_im", want.im, value_im);
                end
            end
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Stimulus
    initial
    begin
        item_t it;
        int pick, n_live, k, spread, count_sel;
        logic kind_sel;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        add_eval(0, 0, 1'b1, 0, 0);
        add_eval(-131072, 131071, 1'b1, 0, 0);
        add_load(0, 32767, -32768, 0, 0, 65536, 65536, 65536, 0);
        add_load(1, 1000, -1000, 0, 0, 0, 65536, 65536, 0);      // zero reciprocal axis
        add_load(2, 4096, 4096, 0, 0, 65536, 65536, 0, 65536);
        add_load(31, -32768, 32767, -131072, 131071, 8388607, -8388608, -131072, 131071);
        add_cfg(CFG_SHAPE_COUNT, CFG_DATA_W'(3));
        add_cfg(CFG_SHAPE_KIND, CFG_DATA_W'(KIND_ELLIPSE));
        add_eval(0, 0, 1'b0, 0, 0);
        add_eval(0, -65536, 1'b0, 0, 0);                         // on the unit boundary
        add_eval(0, -65537, 1'b0, 0, 0);                         // one step outside
        add_eval(131071, -131072, 1'b0, 0, 0);
        add_eval(60000, 0, 1'b0, 0, 0);
        add_eval(-131072, 131071, 1'b0, 0, 0);
        add_cfg(CFG_SHAPE_KIND, CFG_DATA_W'(KIND_DIAMOND));
        add_eval(0, -65536, 1'b0, 0, 0);                         // diamond corner, equal
        add_eval(0, -65537, 1'b0, 0, 0);
        add_eval(32768, -32768, 1'b0, 0, 0);
        add_eval(0, 0, 1'b0, 0, 0);
        add_eval(131071, 131071, 1'b0, 0, 0);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_register(plan[i].idx, plan[i].data);
            else
            begin
                send_item(plan[i].it);
                if (plan[i].known)
                    pending_sums.push_back(plan[i].typed);
                else
                    track_item(plan[i].it);
            end
        end

        // Populate every slot so any count is legal from here on
        for (k = 0; k < MAX_SHAPES; k++)
        begin
            it = random_shape(SLOT_W'(k));
            send_item(it);
            track_item(it);
        end

        // Random phases, each with its own count and kind
        for (int ph = 0; ph < 13; ph++)
        begin
            case (ph)
                0: count_sel = 32;
                1: count_sel = 63;
                2: count_sel = 1;
                3: count_sel = 0;
                4: count_sel = 33;
                5: count_sel = 32;
                default: count_sel = $urandom_range(1, 32);
            endcase
            kind_sel = (ph < 6) ? ph[0] : 1'($urandom_range(0, 1));
            write_register(CFG_SHAPE_COUNT, CFG_DATA_W'(count_sel));
            // upper data bits are don't-care for the kind register
            write_register(CFG_SHAPE_KIND, CFG_DATA_W'({$urandom_range(0, 31), kind_sel}));
            quiet_tail = (ph >= 11);
            repeat (120)
            begin
                pick = $urandom_range(0, 99);
                n_live = (shape_total > MAX_SHAPES) ? MAX_SHAPES : shape_total;
                if (pick < 60)
                begin
                    // point close to where a live shape sits
                    k = (n_live == 0) ? $urandom_range(0, MAX_SHAPES - 1)
                                      : $urandom_range(0, n_live - 1);
                    spread = $urandom_range(500, 40000);
                    it = noise_item();
                    it.op = OP_EVAL;
                    it.pos_x = POS_W'(-int'($signed(shape_mem[k].cen_y))
                               + int'($urandom_range(0, 2 * spread)) - spread);
                    it.pos_y = POS_W'(int'($signed(shape_mem[k].cen_x))
                               + int'($urandom_range(0, 2 * spread)) - spread);
                end
                else if (pick < 75)
                begin
                    it = noise_item();
                    it.op = OP_EVAL;
                    it.pos_x = POS_W'($urandom_range(0, 131072) - 65536);
                    it.pos_y = POS_W'($urandom_range(0, 131072) - 65536);
                end
                else if (pick < 90)
                    it = random_shape(SLOT_W'($urandom_range(0, MAX_SHAPES - 1)));
                else if (pick < 95)
                begin
                    it = noise_item();
                    it.op = OP_EVAL;
                end
                else
                begin
                    it = noise_item();
                    it.op = OP_LOAD;
                end
                send_item(it);
                track_item(it);
            end
        end

        // Drain and settle
        in_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
